// ----- hw/rtl/fdr_pkg.sv -----
// ============================================================================
// Frame rate delay regulator package
// Shared widths, constants, register map and controller command types.
// ============================================================================
package fdr_pkg;

  // Field widths
  localparam int TICK_W  = 32;
  localparam int FT_W    = 16;
  localparam int DELAY_W = 16;
  localparam int CNT_W   = 16;
  localparam int FPS_W   = 10;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_TARGET_FPS = 1'b0;
  localparam logic [FPS_W-1:0] TARGET_FPS_RESET = 10'd60;

  // Measurement window length in ticks
  localparam int WINDOW_MS = 1000;

  // Gain arithmetic: q = floor(target * ft * 8192 / 125)
  localparam int P_W          = FPS_W + FT_W;       // target * ft
  localparam int DIV_BASE     = 125;
  localparam int FRAC_SHIFT   = 13;                 // 65536 / 1000 = 8192 / 125
  localparam int RECIP_W      = 27;
  localparam int RECIP_SHIFT  = 33;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 27'd68719477;  // ceil(2^33 / 125)
  localparam int A_W          = 20;                 // floor(p / 125)
  localparam int R_W          = 7;                  // remainder below 125
  localparam int Q_W          = A_W + FRAC_SHIFT;
  localparam int GAIN_ONE     = 65536;
  localparam int MG_W         = 32;                 // saturated gain magnitude
  localparam int PROD_W       = FT_W + MG_W;
  localparam int STEP_W       = 34;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul_p;
    logic div_a;
    logic rem_a;
    logic div_r;
    logic gain;
    logic mul_g;
    logic step;
    logic apply;
    logic out_load;
  } fdr_cmd_t;

endpackage

// ----- hw/rtl/fdr_in_if.sv -----
// ============================================================================
// Frame event input channel
// Valid/ready channel carrying the wake tick and end tick of one frame.
// ============================================================================
interface fdr_in_if;
  logic                       valid;
  logic                       ready;
  logic [fdr_pkg::TICK_W-1:0] wake_tick;
  logic [fdr_pkg::TICK_W-1:0] end_tick;

  modport source (output valid, output wake_tick, output end_tick, input ready);
  modport sink   (input valid, input wake_tick, input end_tick, output ready);
endinterface

// ----- hw/rtl/fdr_out_if.sv -----
// ============================================================================
// Frame result output channel
// Valid/ready channel carrying the updated sleep delay and rate statistics.
// ============================================================================
interface fdr_out_if;
  logic                        valid;
  logic                        ready;
  logic [fdr_pkg::DELAY_W-1:0] sleep_ms;
  logic [fdr_pkg::TICK_W-1:0]  frame_ms;
  logic [fdr_pkg::CNT_W-1:0]   measured_fps;
  logic                        fps_updated;

  modport source (output valid, output sleep_ms, output frame_ms, output measured_fps,
                  output fps_updated, input ready);
  modport sink   (input valid, input sleep_ms, input frame_ms, input measured_fps,
                  input fps_updated, output ready);
endinterface

// ----- hw/rtl/frame_rate_delay_regulator_top.sv -----
// ============================================================================
// Frame rate delay regulator
// Top level: configuration registers, sequencing controller and datapath.
// ============================================================================
// Each accepted frame event produces exactly one result transaction. The block
// works on one frame at a time. After an event is accepted it passes through
// eight arithmetic steps of the controller: target times frame time, the
// reciprocal divide-by-125 multiply, the remainder, a second divider pass on
// the scaled remainder, gain saturation, the 16 by 32 bit difference times
// gain multiply, the floor shift and the clamped delay update. In a ninth step
// the result is placed in the output register. A new event is accepted only
// once the last result is in the output register; a held result only stalls
// the block once the next event has finished its update.
// Configuration writes through the APB port take effect at once and belong
// to idle periods between frames.
module frame_rate_delay_regulator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdr_pkg::APB_AW-1:0]  paddr,
  input  logic [fdr_pkg::APB_DW-1:0]  pwdata,
  output logic [fdr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  fdr_in_if.sink                      in_ch,
  fdr_out_if.source                   out_ch
);

  logic [fdr_pkg::FPS_W-1:0] target_fps;
  fdr_pkg::fdr_cmd_t         cmd;

  // Configuration registers.
  fdr_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .target_fps (target_fps)
  );

  // Sequencing controller.
  fdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Arithmetic and state datapath.
  fdr_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .target_fps   (target_fps),
    .wake_tick    (in_ch.wake_tick),
    .end_tick     (in_ch.end_tick),
    .sleep_ms     (out_ch.sleep_ms),
    .frame_ms     (out_ch.frame_ms),
    .measured_fps (out_ch.measured_fps),
    .fps_updated  (out_ch.fps_updated)
  );

endmodule

// ----- hw/rtl/fdr_cfg_regs.sv -----
// ============================================================================
// Frame rate delay regulator configuration registers
// APB-style register file holding the target frame rate.
// ============================================================================
module fdr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdr_pkg::APB_AW-1:0]  paddr,
  input  logic [fdr_pkg::APB_DW-1:0]  pwdata,
  output logic [fdr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [fdr_pkg::FPS_W-1:0]   target_fps
);

  logic reg_index;

  // Register index is the word address; byte offset bits are ignored.
  assign reg_index = paddr[2];
  assign pready    = 1'b1;

  // Register write on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_fps <= fdr_pkg::TARGET_FPS_RESET;
    end else if (psel && penable && pwrite && (reg_index == fdr_pkg::REG_TARGET_FPS)) begin
      target_fps <= pwdata[fdr_pkg::FPS_W-1:0];
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_index)
      fdr_pkg::REG_TARGET_FPS: prdata = fdr_pkg::APB_DW'(target_fps);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/fdr_ctrl.sv -----
// ============================================================================
// Frame rate delay regulator controller
// Sequences one frame event through the gain and delay update steps.
// ============================================================================
module fdr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fdr_pkg::fdr_cmd_t cmd
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MUL_P = 10'b0000000010,
    ST_DIV_A = 10'b0000000100,
    ST_REM_A = 10'b0000001000,
    ST_DIV_R = 10'b0000010000,
    ST_GAIN  = 10'b0000100000,
    ST_MUL_G = 10'b0001000000,
    ST_STEP  = 10'b0010000000,
    ST_APPLY = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.mul_p  = 1'b1;
        state_next = ST_DIV_A;
      end
      ST_DIV_A: begin
        cmd.div_a  = 1'b1;
        state_next = ST_REM_A;
      end
      ST_REM_A: begin
        cmd.rem_a  = 1'b1;
        state_next = ST_DIV_R;
      end
      ST_DIV_R: begin
        cmd.div_r  = 1'b1;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = ST_MUL_G;
      end
      ST_MUL_G: begin
        cmd.mul_g  = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/fdr_dpath.sv -----
// ============================================================================
// Frame rate delay regulator datapath
// Frame timing, rate window, Q16 gain computation and delay update.
// ============================================================================
module fdr_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  fdr_pkg::fdr_cmd_t           cmd,
  input  logic [fdr_pkg::FPS_W-1:0]   target_fps,
  input  logic [fdr_pkg::TICK_W-1:0]  wake_tick,
  input  logic [fdr_pkg::TICK_W-1:0]  end_tick,
  output logic [fdr_pkg::DELAY_W-1:0] sleep_ms,
  output logic [fdr_pkg::TICK_W-1:0]  frame_ms,
  output logic [fdr_pkg::CNT_W-1:0]   measured_fps,
  output logic                        fps_updated
);

  localparam int TW   = fdr_pkg::TICK_W;
  localparam int FTW  = fdr_pkg::FT_W;
  localparam int DW   = fdr_pkg::DELAY_W;
  localparam int CW   = fdr_pkg::CNT_W;
  localparam int PW   = fdr_pkg::P_W;
  localparam int AW   = fdr_pkg::A_W;
  localparam int RW   = fdr_pkg::R_W;
  localparam int FS   = fdr_pkg::FRAC_SHIFT;
  localparam int QW   = fdr_pkg::Q_W;
  localparam int MGW  = fdr_pkg::MG_W;
  localparam int PRW  = fdr_pkg::PROD_W;
  localparam int SW   = fdr_pkg::STEP_W;
  localparam int RCW  = fdr_pkg::RECIP_W;
  localparam int RPW  = PW + RCW;

  // Persistent state
  logic [DW-1:0] delay_reg;
  logic [CW-1:0] frame_count;
  logic [CW-1:0] published_fps;
  logic [TW-1:0] window_start;
  logic [TW-1:0] last_end;

  // Per-frame working registers
  logic [TW-1:0]  frame;
  logic [FTW-1:0] ft;
  logic           updated;
  logic [PW-1:0]  p;
  logic [AW-1:0]  a;
  logic [RW-1:0]  r;
  logic [FS-1:0]  b;
  logic [MGW-1:0] mg;
  logic           gneg;
  logic [PRW-1:0] prod;
  logic           pneg;
  logic [SW-1:0]  step_mag;
  logic           step_neg;

  // Combinational helpers
  logic [TW-1:0]  frame_next;
  logic [TW-1:0]  window_age;
  logic [CW-1:0]  count_inc;
  logic [PW-1:0]  recip_op;
  logic [RPW-1:0] recip_prod;
  logic [AW-1:0]  recip_quot;
  logic [PW-1:0]  a_times_base;
  logic [PW-1:0]  rem_full;
  logic [QW-1:0]  q;
  logic [QW:0]    q_over;
  logic [FTW-1:0] abs_diff;
  logic           diff_neg;
  logic [SW-1:0]  s16;
  logic [SW-1:0]  s15;
  logic [SW-1:0]  delay_sum;

  // Frame time and rate window terms at acceptance.
  assign frame_next = wake_tick - last_end;
  assign window_age = wake_tick - window_start;
  assign count_inc  = (frame_count == {CW{1'b1}}) ? frame_count : frame_count + CW'(1);

  // Shared reciprocal divider by 125, used for the whole and the fractional part.
  assign recip_op   = cmd.div_r ? PW'({r, FS'(0)}) : p;
  assign recip_prod = RPW'(recip_op) * RPW'(fdr_pkg::RECIP_MUL);
  assign recip_quot = recip_prod[fdr_pkg::RECIP_SHIFT +: AW];

  // Remainder of p after division by 125.
  assign a_times_base = PW'(a) * PW'(fdr_pkg::DIV_BASE);
  assign rem_full     = p - a_times_base;

  // Gain offset: q = a * 8192 + floor(r * 8192 / 125).
  assign q      = {a, b};
  assign q_over = (QW + 1)'(q) - (QW + 1)'(fdr_pkg::GAIN_ONE);

  // Difference between frame time and current delay, in sign and magnitude.
  assign diff_neg = (ft < delay_reg);
  assign abs_diff = diff_neg ? (delay_reg - ft) : (ft - delay_reg);

  // Floor shifts of the signed product; a negative value rounds away from zero.
  always_comb begin
    if (pneg) begin
      s16 = SW'((PRW + 1)'(prod) + (PRW + 1)'(16'hFFFF) >> 16);
      s15 = SW'((PRW + 1)'(prod) + (PRW + 1)'(15'h7FFF) >> 15);
    end else begin
      s16 = SW'(prod >> 16);
      s15 = SW'(prod >> 15);
    end
  end

  assign delay_sum = SW'(delay_reg) + step_mag;

  // State updated once per accepted frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      published_fps <= '0;
      window_start  <= '0;
      last_end      <= '0;
    end else if (cmd.load) begin
      last_end <= end_tick;
      if (window_age > TW'(fdr_pkg::WINDOW_MS)) begin
        published_fps <= count_inc;
        frame_count   <= '0;
        window_start  <= wake_tick;
      end else begin
        frame_count <= count_inc;
      end
    end
  end

  // Delay register, stepped toward the target when regulation is enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_reg <= '0;
    end else if (cmd.apply && (target_fps != '0)) begin
      if (step_neg) begin
        delay_reg <= (step_mag > SW'(delay_reg)) ? '0 : (delay_reg - step_mag[DW-1:0]);
      end else begin
        delay_reg <= (delay_sum > SW'({DW{1'b1}})) ? {DW{1'b1}} : delay_sum[DW-1:0];
      end
    end
  end

  // Working registers of the update sequence.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame   <= frame_next;
      ft      <= (frame_next > TW'({FTW{1'b1}})) ? {FTW{1'b1}} : frame_next[FTW-1:0];
      updated <= (window_age > TW'(fdr_pkg::WINDOW_MS));
    end
    if (cmd.mul_p) begin
      p <= PW'(target_fps) * PW'(ft);
    end
    if (cmd.div_a) begin
      a <= recip_quot;
    end
    if (cmd.rem_a) begin
      r <= rem_full[RW-1:0];
    end
    if (cmd.div_r) begin
      b <= recip_quot[FS-1:0];
    end
    if (cmd.gain) begin
      // Gain = 65536 - q; a magnitude of 2^32 or more saturates, which still
      // drives the delay to a clamp limit for any nonzero difference.
      if (q_over[QW] || (q_over == '0)) begin
        gneg <= 1'b0;
        mg   <= MGW'((QW + 1)'(fdr_pkg::GAIN_ONE) - (QW + 1)'(q));
      end else begin
        gneg <= 1'b1;
        mg   <= (q_over[QW-1:MGW] != '0) ? {MGW{1'b1}} : q_over[MGW-1:0];
      end
    end
    if (cmd.mul_g) begin
      prod <= PRW'(abs_diff) * PRW'(mg);
      pneg <= diff_neg ^ gneg;
    end
    if (cmd.step) begin
      step_neg <= pneg;
      step_mag <= (s16 == '0) ? s15 : s16;
    end
  end

  // Output register, loaded when the result slot is free.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sleep_ms     <= delay_reg;
      frame_ms     <= frame;
      measured_fps <= published_fps;
      fps_updated  <= updated;
    end
  end

endmodule

// ----- verif/testbench.sv -----
// ============================================================================
// Frame rate delay regulator testbench
// Drives frame events and APB writes of the target rate into the regulator.
// A scoreboard class tracks the sleep delay, the frame counter and the rate
// window in step with the block, and checks each result transaction field
// by field.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int APB_AW  = fdr_pkg::APB_AW;
  localparam int APB_DW  = fdr_pkg::APB_DW;
  localparam int TICK_W  = fdr_pkg::TICK_W;
  localparam int DELAY_W = fdr_pkg::DELAY_W;
  localparam int CNT_W   = fdr_pkg::CNT_W;
  localparam int FPS_W   = fdr_pkg::FPS_W;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 9;
  localparam int PHASE_FRAMES   = 100;
  localparam int BURST_FRAMES   = 120;
  localparam int MAX_PRINTED    = 20;
  localparam logic [APB_AW-1:0] TARGET_FPS_ADDR = APB_AW'(4 * fdr_pkg::REG_TARGET_FPS);

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Sink hold-off and the no-idle stretch.
  logic hold_sink = 1'b0;
  logic quiet     = 1'b0;

  fdr_in_if  in_ch ();
  fdr_out_if out_ch ();

  frame_rate_delay_regulator_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  typedef struct packed {
    logic [DELAY_W-1:0] sleep_ms;
    logic [TICK_W-1:0]  frame_ms;
    logic [CNT_W-1:0]   measured_fps;
    logic               fps_updated;
  } frame_result_t;

  // Mirror of the regulator state plus the queue of results still due.
  class regulator_scoreboard;
    logic [FPS_W-1:0]   target_fps = fdr_pkg::TARGET_FPS_RESET;
    logic [DELAY_W-1:0] delay_ms   = '0;
    logic [CNT_W-1:0]   frame_cnt  = '0;
    logic [CNT_W-1:0]   fps_pub    = '0;
    logic [TICK_W-1:0]  win_start  = '0;
    logic [TICK_W-1:0]  prev_end   = '0;
    frame_result_t      due_results[$];
    int                 errors   = 0;
    int                 frames   = 0;
    int                 checked  = 0;
    int                 windows  = 0;

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    // Works out the result of one accepted frame event and queues it.
    function void expect_frame_result(logic [TICK_W-1:0] wake, logic [TICK_W-1:0] fin);
      logic [TICK_W-1:0] frame;
      logic [TICK_W-1:0] since;
      longint            ft;
      longint            diff;
      longint            q;
      longint            gain;
      longint            prod;
      longint            stepv;
      longint            nd;
      frame_result_t     r;

      frame = wake - prev_end;
      if (frame_cnt != {CNT_W{1'b1}}) frame_cnt++;

      // Delay update through the Q16 gain; frame time saturates at 16 bits.
      if (target_fps != 0) begin
        ft    = (frame > 32'd65535) ? 64'sd65535 : longint'(frame);
        diff  = ft - longint'(delay_ms);
        q     = (longint'(target_fps) * 65536 * ft) / 1000;
        gain  = 65536 - q;
        prod  = diff * gain;
        stepv = prod >>> 16;
        if (stepv == 0) stepv = prod >>> 15;
        nd = longint'(delay_ms) + stepv;
        if (nd < 0) nd = 0;
        if (nd > 65535) nd = 65535;
        delay_ms = nd[DELAY_W-1:0];
      end

      // A window closes only once strictly more than 1000 ms have passed.
      since = wake - win_start;
      r.fps_updated = 1'b0;
      if (since > 32'd1000) begin
        fps_pub   = frame_cnt;
        frame_cnt = '0;
        win_start = wake;
        r.fps_updated = 1'b1;
        windows++;
      end
      prev_end = fin;

      r.sleep_ms     = delay_ms;
      r.frame_ms     = frame;
      r.measured_fps = fps_pub;
      due_results.push_back(r);
      frames++;
    endfunction

    task check_field(string name, logic [TICK_W-1:0] want, logic [TICK_W-1:0] got);
      if (want !== got)
        report($sformatf("result %0d: %s expected 0x%0h, got 0x%0h", checked, name, want, got));
    endtask

    // Compares one result transaction with the oldest outstanding frame.
    task check_result(frame_result_t got);
      frame_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with no frame outstanding: sleep %0d frame %0d",
                         got.sleep_ms, got.frame_ms));
        return;
      end
      want = due_results.pop_front();
      checked++;
      check_field("sleep_ms", want.sleep_ms, got.sleep_ms);
      check_field("frame_ms", want.frame_ms, got.frame_ms);
      check_field("measured_fps", want.measured_fps, got.measured_fps);
      check_field("fps_updated", want.fps_updated, got.fps_updated);
    endtask
  endclass

  regulator_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one frame event, with random idle cycles ahead of it.
  task automatic send_frame(input logic [TICK_W-1:0] wake, input logic [TICK_W-1:0] fin);
    while (!quiet && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.wake_tick <= wake;
    in_ch.end_tick  <= fin;
    do @(posedge clk); while (!in_ch.ready);
    sb.expect_frame_result(wake, fin);
  endtask

  // Stops offering frames and waits until every result has come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the target rate, then a read back of the register.
  task automatic write_target(input logic [FPS_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TARGET_FPS_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.target_fps = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(value))
      sb.report($sformatf("target_fps read back 0x%0h, wrote 0x%0h", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed frame sequences around the nominal frame time, mixed
  // with long frames, near-zero frames, window edges and random ticks.
  task automatic random_frames(input int count, input int nominal);
    logic [TICK_W-1:0] wake;
    logic [TICK_W-1:0] fin;
    int unsigned       kind;
    int unsigned       ft;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        wake = $urandom;
        fin  = $urandom;
      end else if (kind < 12) begin
        wake = sb.win_start + 32'd1000 + $urandom_range(0, 1);
        fin  = wake + $urandom_range(0, 25);
      end else begin
        if (kind < 20) ft = $urandom_range(1000, 200000);
        else if (kind < 26) ft = $urandom_range(0, 3);
        else ft = $urandom_range(nominal / 2, nominal * 2 + 2);
        wake = sb.prev_end + ft;
        fin  = wake + $urandom_range(0, 25);
      end
      send_frame(wake, fin);
    end
  endtask

  // Result side: random ready, held low on request, checked on each handshake.
  initial begin : result_sink
    frame_result_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.sleep_ms     = out_ch.sleep_ms;
        got.frame_ms     = out_ch.frame_ms;
        got.measured_fps = out_ch.measured_fps;
        got.fps_updated  = out_ch.fps_updated;
        sb.check_result(got);
      end
      out_ch.ready <= !hold_sink && (quiet || $urandom_range(99) >= 14);
    end
  end

  // Ends the run when no transaction has moved for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("[frame_rate_delay_regulator_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_fps [PHASES];
    int          nominal;

    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.wake_tick = '0;
    in_ch.end_tick  = '0;

    phase_fps[0] = 60;
    phase_fps[1] = 0;
    phase_fps[2] = 1023;
    phase_fps[3] = 1000;
    phase_fps[4] = 1;
    phase_fps[5] = 144;
    phase_fps[6] = 30;
    phase_fps[7] = $urandom_range(0, 1023);
    phase_fps[8] = $urandom_range(2, 999);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset target rate: zero ticks, the exact window edge, then a closing one.
    send_frame(32'd0, 32'd0);
    send_frame(32'd16, 32'd20);
    send_frame(32'd1000, 32'd1004);
    send_frame(32'd1001, 32'd1003);
    // A frame long enough to saturate the update, then tick extremes and wrap.
    send_frame(32'd71003, 32'd71010);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(32'd5, 32'hFFFF_FFF0);
    send_frame(32'h10, 32'd0);

    // Pull the delay toward 500 ms at a low rate, then drive it into the
    // upper clamp with a rate above 1000.
    wait_idle();
    write_target(10'd1);
    repeat (6) send_frame(sb.prev_end + 32'd500, sb.prev_end + 32'd500);
    wait_idle();
    write_target(10'd1023);
    repeat (3) send_frame(sb.prev_end + 32'd100, sb.prev_end + 32'd100);

    // Regulation off: the delay must hold, even across a long frame.
    wait_idle();
    write_target(10'd0);
    send_frame(sb.prev_end + 32'd40, sb.prev_end + 32'd45);
    send_frame(sb.prev_end + 32'd90000, sb.prev_end + 32'd90003);
    wait_idle();
    write_target(10'd1000);
    send_frame(sb.prev_end + 32'd1, sb.prev_end + 32'd1);
    send_frame(sb.prev_end + 32'd0, sb.prev_end + 32'd2);

    // Random phases, one per target rate setting.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_target(FPS_W'(phase_fps[p]));
      nominal = (phase_fps[p] == 0) ? 20 : 1000 / phase_fps[p];
      if (p == 2) begin
        // Results held back while frames keep coming, so the input stalls.
        fork
          begin
            hold_sink <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_sink <= 1'b0;
          end
          random_frames(PHASE_FRAMES, nominal);
        join
      end else if (p == 4) begin
        random_frames(PHASE_FRAMES / 2, nominal);
        wait_idle();
        random_frames(PHASE_FRAMES - PHASE_FRAMES / 2, nominal);
      end else begin
        random_frames(PHASE_FRAMES, nominal);
      end
    end

    // Back-to-back burst inside one window, with no idling on either side;
    // then one frame closes the window.
    wait_idle();
    quiet <= 1'b1;
    for (int i = 0; i < BURST_FRAMES; i++) begin
      send_frame(sb.win_start + $urandom_range(0, 1000), sb.win_start);
    end
    send_frame(sb.win_start + 32'd1001, sb.win_start + 32'd1005);
    quiet <= 1'b0;

    wait_idle();
    if (sb.due_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.due_results.size()));

    $display("Run covered %0d frame events and %0d result transactions, %0d rate windows.",
             sb.frames, sb.checked, sb.windows);
    $display("Targets from 0 to 1023, a held output, a drained pause and a frame burst.");
    if (sb.errors == 0) begin
      $display("[frame_rate_delay_regulator_top] OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[frame_rate_delay_regulator_top] ERROR");
    end
    $finish;
  end

endmodule
